### hw/rtl/itd_pkg.sv
`default_nettype none
package itd_pkg;

	localparam int MAX_CHARS = 31;
	localparam int CNT_W     = $clog2(MAX_CHARS + 1);
	localparam int DIGITS    = 10;
	localparam int DIG_IDX_W = $clog2(DIGITS);

	localparam logic [7:0]  DIGIT_ZERO = 8'h30;
	localparam logic [7:0]  MINUS_SIGN = 8'h2d;
	localparam logic [7:0]  SPACE_CHAR = 8'h20;
	localparam logic [31:0] RECIP_TEN  = 32'hcccc_cccd;
	localparam int          RECIP_SH   = 35;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CONV,
		ST_PREP,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic load;
		logic step;
		logic prep;
		logic emit;
	} cmd_t;

	typedef struct packed {
		logic conv_done;
		logic out_free;
		logic idx_zero;
	} sts_t;

endpackage
`default_nettype wire

### hw/rtl/itd_ctrl.sv
`default_nettype none
module itd_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_ready,
	input  itd_pkg::sts_t      sts,
	output itd_pkg::cmd_t      cmd
);

	itd_pkg::state_t state_q;
	itd_pkg::state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= itd_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		in_ready = 1'b0;
		cmd      = '0;
		unique case (state_q)
			itd_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = itd_pkg::ST_CONV;
				end
			end
			itd_pkg::ST_CONV: begin
				cmd.step = 1'b1;
				if (sts.conv_done) begin
					state_d = itd_pkg::ST_PREP;
				end
			end
			itd_pkg::ST_PREP: begin
				cmd.prep = 1'b1;
				state_d  = itd_pkg::ST_EMIT;
			end
			itd_pkg::ST_EMIT: begin
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					if (sts.idx_zero) begin
						state_d = itd_pkg::ST_IDLE;
					end
				end
			end
			default: begin
				state_d = itd_pkg::ST_IDLE;
			end
		endcase
	end

endmodule
`default_nettype wire

### hw/rtl/itd_datapath.sv
`default_nettype none
module itd_datapath (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic [31:0]   value,
	input  wire logic [4:0]    min_width,
	input  itd_pkg::cmd_t      cmd,
	output itd_pkg::sts_t      sts,
	output logic [7:0]         char_code,
	output logic               last,
	output logic               out_valid,
	input  wire logic          out_ready
);

	logic [31:0]                   mag_q;
	logic                          neg_q;
	logic [itd_pkg::CNT_W-1:0]     width_q;
	logic [3:0]                    dig_q [itd_pkg::DIGITS];
	logic [itd_pkg::DIG_IDX_W-1:0] ndig_q;
	logic [itd_pkg::CNT_W-1:0]     idx_q;
	logic [7:0]                    char_q;
	logic                          last_q;
	logic                          out_valid_q;

	logic [63:0]                   prod;
	logic [31:0]                   quot;
	logic [31:0]                   quot_x10;
	logic [3:0]                    rem;
	logic [itd_pkg::CNT_W-1:0]     ndig_ext;
	logic [itd_pkg::CNT_W-1:0]     text_len;
	logic [itd_pkg::CNT_W-1:0]     total;
	logic [7:0]                    next_char;

	assign prod     = {32'd0, mag_q} * {32'd0, itd_pkg::RECIP_TEN};
	assign quot     = 32'(prod[63:itd_pkg::RECIP_SH]);
	assign quot_x10 = (quot << 3) + (quot << 1);
	assign rem      = 4'(mag_q - quot_x10);

	assign ndig_ext = itd_pkg::CNT_W'(ndig_q);
	assign text_len = ndig_ext + itd_pkg::CNT_W'(neg_q);
	assign total    = (text_len > width_q) ? text_len : width_q;

	always_comb begin
		if (idx_q >= text_len) begin
			next_char = itd_pkg::SPACE_CHAR;
		end else if (idx_q == ndig_ext) begin
			next_char = itd_pkg::MINUS_SIGN;
		end else begin
			next_char = itd_pkg::DIGIT_ZERO | {4'd0, dig_q[idx_q[itd_pkg::DIG_IDX_W-1:0]]};
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			neg_q  <= value[31];
			mag_q  <= value[31] ? (32'd0 - value) : value;
			ndig_q <= '0;
			if (32'(min_width) > 32'(itd_pkg::MAX_CHARS)) begin
				width_q <= itd_pkg::CNT_W'(itd_pkg::MAX_CHARS);
			end else begin
				width_q <= itd_pkg::CNT_W'(min_width);
			end
		end
		if (cmd.step) begin
			dig_q[ndig_q] <= rem;
			ndig_q        <= ndig_q + 1'b1;
			mag_q         <= quot;
		end
		if (cmd.prep) begin
			idx_q <= total - 1'b1;
		end
		if (cmd.emit) begin
			char_q <= next_char;
			last_q <= (idx_q == '0);
			idx_q  <= idx_q - 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign sts.conv_done = (quot == '0);
	assign sts.out_free  = !out_valid_q || out_ready;
	assign sts.idx_zero  = (idx_q == '0);

	assign char_code = char_q;
	assign last      = last_q;
	assign out_valid = out_valid_q;

endmodule
`default_nettype wire

### hw/rtl/int_to_decimal_padded.sv
// Converts a signed 32-bit value to decimal ASCII, right-justified with leading spaces to at
// least min_width characters (capped at itd_pkg::MAX_CHARS), one character per output request,
// most significant first, last set on the final one. The most negative value prints in full.
// A request is accepted, then the shared divide-by-ten unit yields one decimal digit per cycle
// (1 to 10 digits), a setup state follows, and max(text length, width) characters go out, each
// held until taken. The next request is taken while the last character still waits.
`default_nettype none
module int_to_decimal_padded (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [31:0] value,
	input  wire logic [4:0]  min_width,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [7:0]       char_code,
	output logic             last
);

	itd_pkg::cmd_t cmd;
	itd_pkg::sts_t sts;

	itd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	itd_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.value     (value),
		.min_width (min_width),
		.cmd       (cmd),
		.sts       (sts),
		.char_code (char_code),
		.last      (last),
		.out_valid (out_valid),
		.out_ready (out_ready)
	);

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (char_code == itd_pkg::SPACE_CHAR) || (char_code == itd_pkg::MINUS_SIGN)
			|| ((char_code >= itd_pkg::DIGIT_ZERO) && (char_code <= 8'h39)))
		else $error("illegal character code");

	assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("request accepted while busy");

	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> sts.out_free)
		else $error("character overwritten before taken");

	assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit && sts.idx_zero) |=> (out_valid && last && in_ready))
		else $error("final character not marked");

endmodule
`default_nettype wire

### test/decimal_text_checker.sv
module decimal_text_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic [31:0] value,
	input  logic [4:0]  min_width,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [7:0]  char_code,
	input  logic        last,
	output int          mismatches,
	output int          outstanding
);

	localparam logic [31:0] RADIX = 32'd10;

	typedef struct packed {
		logic [7:0] code;
		logic       last;
	} glyph_t;

	glyph_t expected_chars[$];

	initial begin
		mismatches = 0;
		outstanding = 0;
	end

	function automatic void render_decimal(input logic [31:0] v, input logic [4:0] w);
		logic [31:0] mag;
		logic [7:0]  text[$];
		int          field;
		glyph_t      g;
		mag = v[31] ? (32'd0 - v) : v;
		do begin
			text.push_front(itd_pkg::DIGIT_ZERO + 8'(mag % RADIX));
			mag = mag / RADIX;
		end while (mag != 32'd0);
		if (v[31])
			text.push_front(itd_pkg::MINUS_SIGN);
		field = (int'(w) > itd_pkg::MAX_CHARS) ? itd_pkg::MAX_CHARS : int'(w);
		for (int k = text.size(); k < field; k++) begin
			g.code = itd_pkg::SPACE_CHAR;
			g.last = 1'b0;
			expected_chars.push_back(g);
		end
		foreach (text[k]) begin
			g.code = text[k];
			g.last = (k == text.size() - 1);
			expected_chars.push_back(g);
		end
	endfunction

	task automatic flag_error(input string msg);
		mismatches++;
		if (mismatches <= 10)
			$display("%s", msg);
	endtask

	always @(posedge clk or negedge arst_n) begin
		glyph_t want;
		if (!arst_n) begin
			expected_chars.delete();
		end else begin
			if (in_valid && in_ready)
				render_decimal(value, min_width);
			if (out_valid && out_ready) begin
				if (expected_chars.size() == 0) begin
					flag_error($sformatf("unexpected char_code %02h last %0b",
						char_code, last));
				end else begin
					want = expected_chars.pop_front();
					if (want.code !== char_code)
						flag_error($sformatf("char_code expected %02h got %02h",
							want.code, char_code));
					if (want.last !== last)
						flag_error($sformatf("last expected %0b got %0b (char %02h)",
							want.last, last, want.code));
				end
			end
		end
		outstanding = expected_chars.size();
	end

endmodule

### test/testbench.sv
module testbench;
	logic        clk = 1'b0;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [31:0] value;
	logic [4:0]  min_width;
	logic        out_valid;
	logic        out_ready;
	logic [7:0]  char_code;
	logic        last;
	int          mismatches;
	int          outstanding;
	bit          idle_on;

	int_to_decimal_padded dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.value     (value),
		.min_width (min_width),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.char_code (char_code),
		.last      (last)
	);

	decimal_text_checker checker_i (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.value       (value),
		.min_width   (min_width),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.char_code   (char_code),
		.last        (last),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	always #6 clk = ~clk;

	initial begin
		#15_000_000;
		$display("CHECK FAILED");
		$finish;
	end

	function automatic int draw_gap();
		if (!idle_on)
			return 0;
		return $urandom_range(0, 17);
	endfunction

	function automatic logic [31:0] pick_value();
		logic [31:0] v;
		logic [31:0] p;
		p = 32'd1;
		case ($urandom_range(0, 5))
			0: v = $urandom;
			1: v = $urandom_range(0, 99);
			2: begin
				repeat ($urandom_range(0, 9)) p = p * 32'd10;
				v = p + $urandom_range(0, 2) - 32'd1;
			end
			3: case ($urandom_range(0, 3))
				0: v = 32'h8000_0000;
				1: v = 32'h7fff_ffff;
				2: v = 32'h8000_0001;
				default: v = 32'd0;
			endcase
			default: begin
				repeat ($urandom_range(1, 9)) p = p * 32'd10;
				v = $urandom % p;
			end
		endcase
		if ($urandom_range(0, 1) && v != 32'h8000_0000)
			v = 32'd0 - v;
		return v;
	endfunction

	// enter and leave at a falling edge; valid stays high when no gap follows
	task automatic send_number(input logic [31:0] v, input logic [4:0] w);
		int gap;
		gap = draw_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		value <= v;
		min_width <= w;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		@(negedge clk);
	endtask

	initial begin
		int stall;
		out_ready = 1'b0;
		wait (arst_n);
		forever begin
			@(negedge clk);
			stall = draw_gap();
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			out_ready <= 1'b1;
			@(posedge clk);
			while (!out_valid) @(posedge clk);
		end
	end

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		value = '0;
		min_width = '0;
		idle_on = 1'b1;
		repeat (4) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		send_number(32'd0, 5'd0);
		send_number(32'd0, 5'd31);
		send_number(32'd1, 5'd1);
		send_number(32'hffff_ffff, 5'd0);
		send_number(32'hffff_ffff, 5'd2);
		send_number(32'd9, 5'd3);
		send_number(32'd10, 5'd2);
		send_number(32'hffff_fff6, 5'd3);
		send_number(32'h7fff_ffff, 5'd0);
		send_number(32'h7fff_ffff, 5'd10);
		send_number(32'h7fff_ffff, 5'd31);
		send_number(32'h8000_0000, 5'd0);
		send_number(32'h8000_0000, 5'd11);
		send_number(32'h8000_0000, 5'd12);
		send_number(32'h8000_0000, 5'd31);
		send_number(32'h8000_0001, 5'd5);
		send_number(32'd1_000_000_000, 5'd16);
		send_number(32'd0 - 32'd999_999_999, 5'd1);
		send_number(32'd123_456_789, 5'd30);
		send_number(32'd4_000_000_000, 5'd21);
		idle_on = 1'b0;
		send_number(32'd42, 5'd31);
		send_number(32'd7, 5'd0);
		send_number(32'hffff_ff9c, 5'd4);

		// hold until the output side has drained
		in_valid <= 1'b0;
		wait (outstanding == 0);
		@(negedge clk);

		for (int i = 0; i < 450; i++) begin
			if (i % 50 == 0)
				idle_on = ($urandom_range(0, 3) != 0);
			if (i % 97 == 96) begin
				in_valid <= 1'b0;
				wait (outstanding == 0);
				@(negedge clk);
			end
			send_number(pick_value(), 5'($urandom_range(0, 31)));
		end
		in_valid <= 1'b0;

		wait (outstanding == 0);
		repeat (50) @(posedge clk);
		if (mismatches == 0 && outstanding == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
